>>> rtl/core/tpd_pkg.sv
// Shared types and constants of the turning point detector.
package tpd_pkg;

  localparam int MAX_SAMPLES = 65536;
  localparam int IDX_W       = 16;
  localparam int VAL_W       = 16;
  localparam int POS_W       = 32;

  // Saturation point of the sample index: the smaller of MAX_SAMPLES - 1 and the index range.
  localparam logic [IDX_W-1:0] IDX_LIMIT =
      (MAX_SAMPLES - 1 > (1 << IDX_W) - 1) ? IDX_W'((1 << IDX_W) - 1)
                                           : IDX_W'(MAX_SAMPLES - 1);

  // Output queue geometry.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [7:0] REG_FILTER_ENABLE = 8'd0;
  localparam logic [7:0] REG_THRESHOLD     = 8'd1;

  // Result kinds.
  localparam logic KIND_MIN = 1'b0;
  localparam logic KIND_MAX = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic [IDX_W-1:0]        index;
    logic signed [POS_W-1:0] pos;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } tpd_result_t;

  // Push request into the output queue: up to two records in one cycle.
  typedef struct packed {
    logic        push0;
    logic        push1;
    tpd_result_t rec0;
    tpd_result_t rec1;
  } tpd_push_t;

endpackage

>>> rtl/core/tpd_outq.sv
// Four-entry result queue with a dual write port and a single read port.
module tpd_outq
  import tpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  tpd_push_t   push,
  output logic        room_for_two,
  output logic        rd_valid,
  input  logic        rd_ready,
  output tpd_result_t rd_data
);

  tpd_result_t        mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               pop;
  logic [Q_CNT_W-1:0] n_push;

  assign pop          = rd_valid && rd_ready;
  assign n_push       = Q_CNT_W'(push.push0) + Q_CNT_W'(push.push1);
  assign rd_valid     = (count_r != '0);
  assign rd_data      = mem_r[rd_ptr_r];
  assign room_for_two = (count_r <= Q_CNT_W'(Q_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + Q_PTR_W'(n_push);
    rd_ptr_nxt = rd_ptr_r + Q_PTR_W'(pop);
    count_nxt  = count_r + n_push - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem_r[wr_ptr_r] <= push.rec0;
    end
    if (push.push1) begin
      mem_r[wr_ptr_r + Q_PTR_W'(1)] <= push.rec1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH))
    else $error("result queue overflow");

  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    push.push1 |-> push.push0)
    else $error("second record pushed without the first");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push.push0) |=> (count_r == $past(count_r) - Q_CNT_W'(1)))
    else $error("queue count did not drop on a lone read");

endmodule

>>> rtl/core/turning_point_detector.sv
// Top level of the turning point detector: sample tracking, filter and result queue.
// Results pass through the result queue registers before they are offered on the output.
// Throughput: one input beat per cycle; the third sample of a sequence may yield two
//   result beats, which the four-entry result queue absorbs, so input only pauses
//   when the queue holds more than two undelivered results.
// Reset: synchronous active-low rst_n clears the sequence state, both registers and the queue.
module turning_point_detector
  import tpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [31:0] pos_x, [47:32] sample
  input  logic [0:0]  in_tuser,   // [0] start_req
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [15:0] index, [47:16] pos_x_out, [63:48] value_out
  output logic [0:0]  out_tuser,  // [0] kind
  output logic        out_tlast,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers.
  logic                    filter_en_r;
  logic signed [VAL_W-1:0] threshold_r;

  // Sequence state.
  logic                    in_seq_r,     in_seq_nxt;
  logic signed [VAL_W-1:0] prev_r,       prev_nxt;
  logic                    falling_r,    falling_nxt;
  logic [IDX_W-1:0]        cnt_r,        cnt_nxt;
  logic                    held_valid_r, held_valid_nxt;
  logic                    held_kind_r,  held_kind_nxt;
  logic signed [POS_W-1:0] held_pos_r,   held_pos_nxt;
  logic signed [VAL_W-1:0] held_val_r,   held_val_nxt;

  logic                    acc;
  logic                    start;
  logic                    active;
  logic signed [POS_W-1:0] pos;
  logic signed [VAL_W-1:0] val;
  logic [IDX_W-1:0]        idx_inc;
  logic                    rising;
  logic                    dropping;
  logic                    found;
  logic                    kind;
  logic                    hold_case;
  logic                    emit_held;
  logic                    emit_new;
  tpd_push_t               push;
  tpd_result_t             rd_rec;
  logic                    room_for_two;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_en_r <= 1'b0;
      threshold_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FILTER_ENABLE: filter_en_r <= cfg_data[0];
        REG_THRESHOLD:     threshold_r <= cfg_data;
        default:           ;
      endcase
    end
  end

  // The input side only waits on queue space, never on the result side directly.
  assign in_tready = room_for_two;
  assign acc       = in_tvalid && in_tready;
  assign start     = in_tuser[0];
  assign pos       = in_tdata[31:0];
  assign val       = in_tdata[47:32];
  assign active    = acc && !start && in_seq_r;

  // The index saturates, but later samples are still examined.
  assign idx_inc   = (cnt_r != IDX_LIMIT) ? cnt_r + IDX_W'(1) : cnt_r;
  assign rising    = (val > prev_r);
  assign dropping  = (val < prev_r);
  assign kind      = dropping ? KIND_MAX : KIND_MIN;

  // A rise after a fall is a minimum and a fall after a rise a maximum; the filter
  // uses the register values of the moment the extremum is found.
  assign found = ((rising && falling_r) || (dropping && !falling_r)) &&
                 (!filter_en_r || (val > threshold_r));

  // At the second sample an extremum is only held; it comes out with the third.
  assign hold_case = (idx_inc == IDX_W'(1));
  assign emit_held = active && !hold_case && held_valid_r;
  assign emit_new  = active && !hold_case && found;

  always_comb begin
    push            = '0;
    push.rec0.kind  = emit_held ? held_kind_r : kind;
    push.rec0.index = emit_held ? IDX_W'(1) : idx_inc;
    push.rec0.pos   = emit_held ? held_pos_r : pos;
    push.rec0.value = emit_held ? held_val_r : val;
    push.rec0.last  = !(emit_held && emit_new);
    push.rec1.kind  = kind;
    push.rec1.index = idx_inc;
    push.rec1.pos   = pos;
    push.rec1.value = val;
    push.rec1.last  = 1'b1;
    push.push0      = emit_held || emit_new;
    push.push1      = emit_held && emit_new;
  end

  always_comb begin
    in_seq_nxt     = in_seq_r;
    prev_nxt       = prev_r;
    falling_nxt    = falling_r;
    cnt_nxt        = cnt_r;
    held_valid_nxt = held_valid_r;
    held_kind_nxt  = held_kind_r;
    held_pos_nxt   = held_pos_r;
    held_val_nxt   = held_val_r;
    if (acc && start) begin
      // A new sequence drops anything held and restarts at index 0, ascending.
      in_seq_nxt     = 1'b1;
      prev_nxt       = val;
      falling_nxt    = 1'b0;
      cnt_nxt        = '0;
      held_valid_nxt = 1'b0;
    end else if (active) begin
      cnt_nxt  = idx_inc;
      prev_nxt = val;
      // A flat step keeps the direction.
      if (rising) begin
        falling_nxt = 1'b0;
      end else if (dropping) begin
        falling_nxt = 1'b1;
      end
      if (hold_case) begin
        if (found) begin
          held_valid_nxt = 1'b1;
          held_kind_nxt  = kind;
          held_pos_nxt   = pos;
          held_val_nxt   = val;
        end
      end else begin
        held_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_seq_r     <= 1'b0;
      prev_r       <= '0;
      falling_r    <= 1'b0;
      cnt_r        <= '0;
      held_valid_r <= 1'b0;
      held_kind_r  <= 1'b0;
      held_pos_r   <= '0;
      held_val_r   <= '0;
    end else begin
      in_seq_r     <= in_seq_nxt;
      prev_r       <= prev_nxt;
      falling_r    <= falling_nxt;
      cnt_r        <= cnt_nxt;
      held_valid_r <= held_valid_nxt;
      held_kind_r  <= held_kind_nxt;
      held_pos_r   <= held_pos_nxt;
      held_val_r   <= held_val_nxt;
    end
  end

  tpd_outq u_outq (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .room_for_two (room_for_two),
    .rd_valid     (out_tvalid),
    .rd_ready     (out_tready),
    .rd_data      (rd_rec)
  );

  assign out_tdata = {rd_rec.value, rd_rec.pos, rd_rec.index};
  assign out_tuser = rd_rec.kind;
  assign out_tlast = rd_rec.last;

  a_held_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
    held_valid_r |-> in_seq_r)
    else $error("extremum held outside a sequence");

  a_pair_at_third: assert property (@(posedge clk) disable iff (!rst_n)
    push.push1 |-> (cnt_nxt == IDX_W'(2)))
    else $error("two results from a sample other than the third");

  a_start_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && start) |-> !push.push0)
    else $error("sequence start produced a result");

endmodule
